// ===== sv/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [31:0] value;
    logic        [7:0]  prio;
  } entry_t;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] item_value;
    logic        [7:0]  item_priority;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic        [7:0]  out_priority;
    logic        [1:0]  status;
    logic        [3:0]  entry_count;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/sorted_array_priority_queue.sv =====
// Insert moves each lower-priority entry back from the rear, then places the new entry;
//   remove reads the head, then shifts the rest forward. Full insert / empty remove: result
//   in the next cycle. One transaction at a time; the single entry memory
//   (one read, one write per cycle) carries every shift step.
// Reset: rst (synchronous) empties the queue; memory contents are not cleared.
// The receiver cannot stall: done pulses for exactly one cycle with the result.
`default_nettype none

module sorted_array_priority_queue #(
  parameter int DEPTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire spq_pkg::cmd_t    item,
  output logic                  done,
  output spq_pkg::result_t      result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    IDLE,
    INS_SHIFT,   // walk down from the rear, moving lower-priority entries back
    INS_PLACE,   // drop the new entry into the opened slot
    REM_HEAD,    // head entry arrives from memory
    REM_SHIFT    // move the remaining entries forward
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [AW-1:0]     idx;        // insert: slot being filled; remove: slot being read
  spq_pkg::entry_t   new_entry;
  spq_pkg::entry_t   head;

  // memory port
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  spq_pkg::entry_t   mem_wdata;
  logic [AW-1:0]     mem_raddr;
  spq_pkg::entry_t   mem_rdata;

  logic              accept;
  logic              move_back;  // stored entry has strictly lower priority than new one

  assign busy      = (state != IDLE);
  assign accept    = start && !busy;
  assign move_back = (new_entry.prio > mem_rdata.prio);

  spq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Memory control. Reads are issued one step ahead so a shift step retires
  // every cycle; the read and write addresses of a shift step never coincide.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = new_entry;
    mem_raddr = '0;
    case (state)
      IDLE: begin
        if (item.opcode == spq_pkg::OP_INSERT) begin
          mem_raddr = AW'(count - CW'(1));
        end
      end
      INS_SHIFT: begin
        mem_we = 1'b1;
        if (move_back) begin
          mem_wdata = mem_rdata;
          mem_raddr = idx - AW'(1) - AW'(1);
        end
      end
      INS_PLACE: begin
        mem_we = 1'b1;
      end
      REM_HEAD: begin
        mem_raddr = AW'(1);
      end
      REM_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx - AW'(1);
        mem_wdata = mem_rdata;
        mem_raddr = idx + AW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      idx   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (accept) begin
            new_entry.value <= item.item_value;
            new_entry.prio  <= item.item_priority;
            if (item.opcode == spq_pkg::OP_INSERT) begin
              if (count >= CW'(DEPTH)) begin
                done               <= 1'b1;
                result.out_value   <= '0;
                result.out_priority <= '0;
                result.status      <= spq_pkg::ST_FULL;
                result.entry_count <= 4'(count);
              end else if (count == '0) begin
                idx   <= '0;
                state <= INS_PLACE;
              end else begin
                idx   <= AW'(count);
                state <= INS_SHIFT;
              end
            end else begin
              if (count == '0) begin
                done               <= 1'b1;
                result.out_value   <= '0;
                result.out_priority <= '0;
                result.status      <= spq_pkg::ST_EMPTY;
                result.entry_count <= 4'(count);
              end else begin
                state <= REM_HEAD;
              end
            end
          end
        end
        INS_SHIFT: begin
          if (move_back) begin
            idx <= idx - AW'(1);
            if (idx == AW'(1)) begin
              state <= INS_PLACE;
            end
          end else begin
            count              <= count + CW'(1);
            done               <= 1'b1;
            result.out_value   <= '0;
            result.out_priority <= '0;
            result.status      <= spq_pkg::ST_DONE;
            result.entry_count <= 4'(count + CW'(1));
            state              <= IDLE;
          end
        end
        INS_PLACE: begin
          count              <= count + CW'(1);
          done               <= 1'b1;
          result.out_value   <= '0;
          result.out_priority <= '0;
          result.status      <= spq_pkg::ST_DONE;
          result.entry_count <= 4'(count + CW'(1));
          state              <= IDLE;
        end
        REM_HEAD: begin
          head <= mem_rdata;
          if (count == CW'(1)) begin
            count               <= '0;
            done                <= 1'b1;
            result.out_value    <= mem_rdata.value;
            result.out_priority <= mem_rdata.prio;
            result.status       <= spq_pkg::ST_DONE;
            result.entry_count  <= '0;
            state               <= IDLE;
          end else begin
            idx   <= AW'(1);
            state <= REM_SHIFT;
          end
        end
        REM_SHIFT: begin
          if (idx == AW'(count - CW'(1))) begin
            count               <= count - CW'(1);
            done                <= 1'b1;
            result.out_value    <= head.value;
            result.out_priority <= head.prio;
            result.status       <= spq_pkg::ST_DONE;
            result.entry_count  <= 4'(count - CW'(1));
            state               <= IDLE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // Occupancy never exceeds the array size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above DEPTH");

  // A result is only presented once the controller has returned to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Insert into a full queue is answered next cycle with full status.
  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (accept && item.opcode == spq_pkg::OP_INSERT && count == CW'(DEPTH))
      |=> (done && result.status == spq_pkg::ST_FULL))
    else $error("full insert not rejected");

  // The memory is never written while idle.
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> !mem_we)
    else $error("memory write while idle");

endmodule

`default_nettype wire

// ===== sv/spq_mem.sv =====
`default_nettype none

// Single-port-write, single-port-read entry store, registered read data.
module spq_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire spq_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output spq_pkg::entry_t      rdata
);

  spq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== bench/spq_order_check.sv =====
`default_nettype none

// Watches the command and result channels, keeps a shadow of the sorted
// array and compares each result with the oldest outstanding prediction.
module spq_order_check #(
  parameter int DEPTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire spq_pkg::cmd_t    item,
  input  wire logic             done,
  input  wire spq_pkg::result_t result,
  output int                    errors,
  output int                    outstanding,
  output int                    results_seen,
  output int                    full_rejects,
  output int                    empty_removes
);

  spq_pkg::entry_t  slots [DEPTH];
  int unsigned      fill;
  spq_pkg::result_t predicted_results [$];
  spq_pkg::result_t want;

  // Applies one command to the shadow array, highest priority in slot 0.
  task automatic serve_command(input spq_pkg::cmd_t c, output spq_pkg::result_t r);
    int pos;
    int k;
    r = '0;
    if (c.opcode == spq_pkg::OP_INSERT) begin
      if (fill >= DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // new entry lands behind every entry of equal or higher priority
        pos = fill;
        while (pos > 0 && c.item_priority > slots[pos-1].prio) begin
          slots[pos] = slots[pos-1];
          pos--;
        end
        slots[pos].value = c.item_value;
        slots[pos].prio  = c.item_priority;
        fill++;
      end
    end else begin
      if (fill == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.out_value    = slots[0].value;
        r.out_priority = slots[0].prio;
        for (k = 1; k < fill; k++) slots[k-1] = slots[k];
        fill--;
      end
    end
    r.entry_count = fill[3:0];
  endtask

  task automatic check_field(input string fname, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", fname, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      predicted_results.delete();
    end else begin
      // results first: a result never belongs to a command taken at the same edge
      if (done) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          $error("result strobe with no transaction outstanding");
          errors++;
        end else begin
          want = predicted_results.pop_front();
          check_field("out_value", longint'(want.out_value), longint'(result.out_value));
          check_field("out_priority", want.out_priority, result.out_priority);
          check_field("status", want.status, result.status);
          check_field("entry_count", want.entry_count, result.entry_count);
        end
      end
      if (start && !busy) begin
        serve_command(item, want);
        if (want.status == spq_pkg::ST_FULL) full_rejects++;
        if (want.status == spq_pkg::ST_EMPTY) empty_removes++;
        predicted_results.push_back(want);
      end
    end
    outstanding <= predicted_results.size();
  end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;

  localparam int DEPTH       = 8;
  localparam int N_RANDOM    = 1425;
  localparam int QUIET_TAIL  = 200;   // last random transactions go back to back
  localparam int STALL_LIMIT = 2000;  // cycles with no command or result accepted

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic             done;
  spq_pkg::cmd_t    item;
  spq_pkg::result_t result;

  int errors;
  int outstanding;
  int results_seen;
  int full_rejects;
  int empty_removes;
  int stall_cycles = 0;
  int issued = 0;
  int directed_n = 0;

  // 8-unit clock period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  sorted_array_priority_queue #(
    .DEPTH(DEPTH)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done),
    .result(result)
  );

  spq_order_check #(
    .DEPTH(DEPTH)
  ) order_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .done         (done),
    .result       (result),
    .errors       (errors),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .full_rejects (full_rejects),
    .empty_removes(empty_removes)
  );

  // Watchdog: any accepted command or result restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    do @(posedge clk); while (stall_cycles < STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic spq_pkg::cmd_t make_cmd(input logic op, input logic [31:0] v,
                                             input logic [7:0] p);
    spq_pkg::cmd_t c;
    c.opcode        = op;
    c.item_value    = v;
    c.item_priority = p;
    return c;
  endfunction

  // Drive at the falling edge, hold start until the block takes the transaction.
  // start stays high afterwards so back-to-back commands need no extra edge.
  task automatic issue(input spq_pkg::cmd_t c);
    @(negedge clk);
    start <= 1'b1;
    item  <= c;
    do @(posedge clk); while (busy);
    issued++;
  endtask

  // drop start low and idle before the next command
  task automatic pause(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_pause(input bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) pause($urandom_range(1, 8));
  endtask

  // values lean on the sign and all-ones corners now and then
  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] random_priority();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stimulus
    int       r;
    int       j;
    int       seg_len;
    int       ins_pct;
    bit       gappy;
    bit       tie_mode;
    logic [7:0] tie_base;
    logic [7:0] pri;
    logic     op;

    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed: empty remove, fill to full with ties and extremes,
    //     rejected inserts, drain in priority/arrival order, empty again
    issue(make_cmd(spq_pkg::OP_REMOVE, 32'hFFFF_FFFF, 8'hFF));  maybe_pause(1);
    issue(make_cmd(spq_pkg::OP_INSERT, 32'h7FFF_FFFF, 8'd0));   maybe_pause(1);
    issue(make_cmd(spq_pkg::OP_INSERT, 32'h8000_0000, 8'd255)); maybe_pause(1);
    issue(make_cmd(spq_pkg::OP_INSERT, 32'h0000_0000, 8'd255)); // tie behind previous
    issue(make_cmd(spq_pkg::OP_INSERT, 32'hFFFF_FFFF, 8'd128)); maybe_pause(1);
    issue(make_cmd(spq_pkg::OP_INSERT, 32'h0000_0001, 8'd0));   // tie at the rear
    issue(make_cmd(spq_pkg::OP_INSERT, 32'h5555_5555, 8'd1));
    issue(make_cmd(spq_pkg::OP_INSERT, 32'hAAAA_AAAA, 8'd254)); maybe_pause(1);
    issue(make_cmd(spq_pkg::OP_INSERT, 32'd123, 8'd128));       // queue now full
    issue(make_cmd(spq_pkg::OP_INSERT, 32'h1234_5678, 8'd255)); // rejected: full
    issue(make_cmd(spq_pkg::OP_INSERT, 32'h0F0F_0F0F, 8'd0));   // rejected: full
    repeat (DEPTH) begin
      issue(make_cmd(spq_pkg::OP_REMOVE, $urandom, 8'($urandom_range(0, 255))));
      maybe_pause(1);
    end
    issue(make_cmd(spq_pkg::OP_REMOVE, 32'h0000_0000, 8'h00));  // empty again
    issue(make_cmd(spq_pkg::OP_INSERT, 32'd7, 8'd9));
    issue(make_cmd(spq_pkg::OP_REMOVE, 32'd0, 8'd0));
    issue(make_cmd(spq_pkg::OP_REMOVE, 32'd0, 8'd0));
    directed_n = issued;

    // --- random: segments with an insert/remove bias so the queue swings
    //     between empty and full; some segments draw priorities from a narrow
    //     band to force long runs of equal priorities
    r = 0;
    while (r < N_RANDOM) begin
      seg_len = $urandom_range(10, 40);
      case ($urandom_range(0, 2))
        0:       ins_pct = 80;
        1:       ins_pct = 50;
        default: ins_pct = 25;
      endcase
      gappy    = ($urandom_range(0, 1) == 1);
      tie_mode = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 2))
        0:       tie_base = 8'd0;
        1:       tie_base = 8'd126;
        default: tie_base = 8'd252;
      endcase
      for (j = 0; j < seg_len && r < N_RANDOM; j++) begin
        op  = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
        pri = tie_mode ? tie_base + 8'($urandom_range(0, 3)) : random_priority();
        issue(make_cmd(op, random_value(), pri));
        r++;
        maybe_pause(gappy && r < N_RANDOM - QUIET_TAIL);
      end
    end

    @(negedge clk);
    start <= 1'b0;

    // drain, then wait on to catch any stray result strobe
    while (outstanding != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);

    $display("%0d transactions (%0d directed, %0d random), %0d results checked",
             issued, directed_n, issued - directed_n, results_seen);
    $display("%0d inserts rejected on full queue, %0d removes on empty queue, depth %0d",
             full_rejects, empty_removes, DEPTH);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
sv/spq_pkg.sv
sv/spq_mem.sv
sv/sorted_array_priority_queue.sv
bench/spq_order_check.sv
bench/tb_top.sv
